/* rtl/ledpg_pkg.sv */
// Package for the LED pattern generator.
// Holds register indexes, mode and pattern codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package ledpg_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int PERIOD_W    = 16;
  localparam int DUTY_W      = 7;
  localparam int LEVEL_W     = 8;
  localparam int DIVISOR_W   = 16;

  // Width of the largest non-time dividend: ramp*255.
  localparam int MIN_DIV_W   = 24;

  // On time = period*duty/100 by reciprocal multiply: ceil(2^30/100), exact below 2^23.
  localparam int ON_PROD_W      = PERIOD_W + DUTY_W;
  localparam int ON_RECIP_W     = 24;
  localparam int ON_SCALED_W    = ON_PROD_W + ON_RECIP_W;
  localparam int ON_RECIP_SHIFT = 30;
  localparam logic [ON_RECIP_W-1:0] ON_RECIP = 24'd10737419;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DUTY    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEATS = 2'd3;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;
  localparam logic [1:0] MODE_BREATH = 2'd3;

  localparam logic [PERIOD_W-1:0] BLINK_MIN_PERIOD  = 16'd10;
  localparam logic [PERIOD_W-1:0] BREATH_MIN_PERIOD = 16'd100;
  localparam logic [DUTY_W-1:0]   DUTY_LIMIT        = 7'd100;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL        = 8'd255;
  localparam logic [LEVEL_W-1:0]  LEVEL_DARK        = 8'd0;

  typedef enum logic [2:0] {
    PAT_OFF    = 3'd0,
    PAT_ON     = 3'd1,
    PAT_BLINK  = 3'd2,
    PAT_BLINKN = 3'd3,
    PAT_BREATH = 3'd4
  } pat_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic on_calc;
    logic on_apply;
    logic main_div_start;
    logic breath_div_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic blink_pending;
    logic timed;
    logic breath_div_needed;
    logic div_busy;
    logic emit;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/ledpg_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Used by the datapath; depends on ledpg_pkg for the divisor width.
`timescale 1ns / 1ps

module ledpg_div
  import ledpg_pkg::*;
#(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DW-1:0]        quotient,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]        quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = CW'(DW);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[DW-2:0], fits};
      // remainder stays below the divisor, so the low bits are enough
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = cnt_r != '0;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/ledpg_datapath.sv */
// Datapath: configuration registers, active pattern state, shared divider and result register.
// Depends on ledpg_pkg and ledpg_div; driven by ledpg_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps

module ledpg_datapath
  import ledpg_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [TIME_BITS-1:0]   in_now_ms,
  input  ctrl_cmd_t              cmd,
  output dp_sts_t                sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEVEL_W-1:0]     out_brightness,
  output logic                   out_settings_rejected,
  output logic                   out_count_finished
);

  localparam int DW = (TIME_BITS > MIN_DIV_W) ? TIME_BITS : MIN_DIV_W;

  logic [1:0]           mode_r, mode_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic [PERIOD_W-1:0]  repeats_r, repeats_nxt;
  logic                 pending_r, pending_nxt;

  pat_t                 pattern_r, pattern_nxt;
  logic [PERIOD_W-1:0]  act_period_r, act_period_nxt;
  logic [PERIOD_W-1:0]  act_on_r, act_on_nxt;
  logic [PERIOD_W-1:0]  act_repeats_r, act_repeats_nxt;
  logic [TIME_BITS-1:0] phase_r, phase_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 rejected_r, rejected_nxt;
  logic [LEVEL_W-1:0]   last_level_r, last_level_nxt;
  logic                 emitted_r, emitted_nxt;
  logic [ON_PROD_W-1:0] on_prod_r, on_prod_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                 out_rej_r, out_rej_nxt;
  logic                 out_fin_r, out_fin_nxt;

  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_busy;
  logic [DW-1:0]        div_quo;
  logic [DIVISOR_W-1:0] div_rem;

  logic                 blink_ok;
  logic [ON_SCALED_W-1:0] on_scaled;
  logic [PERIOD_W-1:0]  on_time;
  logic [TIME_BITS-1:0] elapsed;
  logic [PERIOD_W-2:0]  half;
  logic [PERIOD_W-1:0]  ramp;
  logic [MIN_DIV_W-1:0] ramp_scaled;

  logic [LEVEL_W-1:0]   target;
  logic                 finished;
  pat_t                 pattern_after;
  logic                 per_zero;
  logic                 in_on_part;
  logic                 emit;

  assign blink_ok = (period_r >= BLINK_MIN_PERIOD) && (duty_r != '0) && (duty_r < DUTY_LIMIT);
  assign on_scaled  = ON_SCALED_W'(on_prod_r) * ON_SCALED_W'(ON_RECIP);
  assign on_time    = on_scaled[ON_RECIP_SHIFT +: PERIOD_W];
  assign elapsed    = now_r - phase_r;
  assign half       = act_period_r[PERIOD_W-1:1];
  assign per_zero   = act_period_r == '0;

  // descending half of the triangle uses the distance to the period end
  always_comb begin
    if (div_rem < {1'b0, half}) begin
      ramp = div_rem;
    end else begin
      ramp = act_period_r - div_rem;
    end
    ramp_scaled = {ramp, 8'd0} - MIN_DIV_W'(ramp);
  end

  always_comb begin
    div_start    = cmd.main_div_start | cmd.breath_div_start;
    div_dividend = DW'(elapsed);
    div_divisor  = act_period_r;
    if (cmd.breath_div_start) begin
      div_dividend = DW'(ramp_scaled);
      div_divisor  = {1'b0, half};
    end
  end

  ledpg_div #(
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // level for the current poll, from the divider results
  always_comb begin
    target        = LEVEL_DARK;
    finished      = 1'b0;
    pattern_after = pattern_r;
    in_on_part    = div_rem < act_on_r;
    case (pattern_r)
      PAT_ON: begin
        target = LEVEL_FULL;
      end
      PAT_BLINK: begin
        if (!per_zero && in_on_part) begin
          target = LEVEL_FULL;
        end
      end
      PAT_BLINKN: begin
        if (per_zero || (div_quo >= DW'(act_repeats_r))) begin
          pattern_after = PAT_OFF;
          finished      = 1'b1;
        end else if (in_on_part) begin
          target = LEVEL_FULL;
        end
      end
      PAT_BREATH: begin
        if (!per_zero && (half != '0)) begin
          // odd period: the falling half can overshoot, saturate
          target = (div_quo > DW'(LEVEL_FULL)) ? LEVEL_FULL : div_quo[LEVEL_W-1:0];
        end
      end
      PAT_OFF: begin
        target = LEVEL_DARK;
      end
      default: begin
        pattern_after = PAT_OFF;
      end
    endcase
    emit = !emitted_r || (target != last_level_r) || rejected_r || finished;
  end

  always_comb begin
    mode_nxt        = mode_r;
    period_nxt      = period_r;
    duty_nxt        = duty_r;
    repeats_nxt     = repeats_r;
    pending_nxt     = pending_r;
    pattern_nxt     = pattern_r;
    act_period_nxt  = act_period_r;
    act_on_nxt      = act_on_r;
    act_repeats_nxt = act_repeats_r;
    phase_nxt       = phase_r;
    now_nxt         = now_r;
    rejected_nxt    = rejected_r;
    last_level_nxt  = last_level_r;
    emitted_nxt     = emitted_r;
    on_prod_nxt     = on_prod_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_level_nxt   = out_level_r;
    out_rej_nxt     = out_rej_r;
    out_fin_nxt     = out_fin_r;

    if (cfg_we) begin
      pending_nxt = 1'b1;
      case (cfg_index)
        CFG_MODE:    mode_nxt    = cfg_wdata[1:0];
        CFG_PERIOD:  period_nxt  = cfg_wdata[PERIOD_W-1:0];
        CFG_DUTY:    duty_nxt    = cfg_wdata[DUTY_W-1:0];
        CFG_REPEATS: repeats_nxt = cfg_wdata[PERIOD_W-1:0];
        default:     pending_nxt = pending_r;
      endcase
    end

    if (cmd.accept) begin
      now_nxt      = in_now_ms;
      rejected_nxt = 1'b0;
    end

    if (cmd.on_calc) begin
      on_prod_nxt = ON_PROD_W'(period_r) * ON_PROD_W'(duty_r);
    end

    if (cmd.check && pending_r) begin
      pending_nxt = 1'b0;
      case (mode_r)
        MODE_OFF: begin
          pattern_nxt = PAT_OFF;
          phase_nxt   = now_r;
        end
        MODE_ON: begin
          pattern_nxt = PAT_ON;
          phase_nxt   = now_r;
        end
        MODE_BLINK: begin
          // valid blink settings finish once the on time is known
          if (!blink_ok) begin
            rejected_nxt = 1'b1;
          end
        end
        MODE_BREATH: begin
          if (period_r < BREATH_MIN_PERIOD) begin
            rejected_nxt = 1'b1;
          end else begin
            pattern_nxt    = PAT_BREATH;
            act_period_nxt = period_r;
            phase_nxt      = now_r;
          end
        end
        default: begin
          rejected_nxt = 1'b1;
        end
      endcase
    end

    if (cmd.on_apply) begin
      if (on_time == '0) begin
        rejected_nxt = 1'b1;
      end else begin
        pattern_nxt     = (repeats_r != '0) ? PAT_BLINKN : PAT_BLINK;
        act_period_nxt  = period_r;
        act_on_nxt      = on_time;
        act_repeats_nxt = repeats_r;
        phase_nxt       = now_r;
      end
    end

    if (cmd.finish) begin
      pattern_nxt = pattern_after;
      if (emit) begin
        last_level_nxt = target;
        emitted_nxt    = 1'b1;
        out_valid_nxt  = 1'b1;
        out_level_nxt  = target;
        out_rej_nxt    = rejected_r;
        out_fin_nxt    = finished;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_OFF;
      period_r      <= '0;
      duty_r        <= '0;
      repeats_r     <= '0;
      pending_r     <= 1'b0;
      pattern_r     <= PAT_OFF;
      act_period_r  <= '0;
      act_on_r      <= '0;
      act_repeats_r <= '0;
      phase_r       <= '0;
      rejected_r    <= 1'b0;
      last_level_r  <= '0;
      emitted_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      period_r      <= period_nxt;
      duty_r        <= duty_nxt;
      repeats_r     <= repeats_nxt;
      pending_r     <= pending_nxt;
      pattern_r     <= pattern_nxt;
      act_period_r  <= act_period_nxt;
      act_on_r      <= act_on_nxt;
      act_repeats_r <= act_repeats_nxt;
      phase_r       <= phase_nxt;
      rejected_r    <= rejected_nxt;
      last_level_r  <= last_level_nxt;
      emitted_r     <= emitted_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    now_r       <= now_nxt;
    on_prod_r   <= on_prod_nxt;
    out_level_r <= out_level_nxt;
    out_rej_r   <= out_rej_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  always_comb begin
    sts.blink_pending     = pending_r && (mode_r == MODE_BLINK) && blink_ok;
    sts.timed             = !per_zero && ((pattern_r == PAT_BLINK) ||
                            (pattern_r == PAT_BLINKN) || (pattern_r == PAT_BREATH));
    sts.breath_div_needed = (pattern_r == PAT_BREATH) && (half != '0);
    sts.div_busy          = div_busy;
    sts.emit              = emit;
    sts.out_free          = !out_valid_r || out_ready;
  end

  assign out_valid             = out_valid_r;
  assign out_brightness        = out_level_r;
  assign out_settings_rejected = out_rej_r;
  assign out_count_finished    = out_fin_r;

endmodule

/* rtl/ledpg_ctrl.sv */
// Controller state machine: sequences settings check, divisions and result hand-off.
// Depends on ledpg_pkg; drives ledpg_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module ledpg_ctrl
  import ledpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_ONCALC = 7'b0000100,
    S_PHASE  = 7'b0001000,
    S_MDIV   = 7'b0010000,
    S_BDIV   = 7'b0100000,
    S_LEVEL  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.blink_pending) begin
          cmd.on_calc = 1'b1;
          state_nxt   = S_ONCALC;
        end else begin
          state_nxt = S_PHASE;
        end
      end
      S_ONCALC: begin
        cmd.on_apply = 1'b1;
        state_nxt    = S_PHASE;
      end
      S_PHASE: begin
        if (sts.timed) begin
          cmd.main_div_start = 1'b1;
          state_nxt          = S_MDIV;
        end else begin
          state_nxt = S_LEVEL;
        end
      end
      S_MDIV: begin
        if (!sts.div_busy) begin
          if (sts.breath_div_needed) begin
            cmd.breath_div_start = 1'b1;
            state_nxt            = S_BDIV;
          end else begin
            state_nxt = S_LEVEL;
          end
        end
      end
      S_BDIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        // hold while a result is due and the output register is still full
        if (!sts.emit || sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

endmodule

/* rtl/led_pattern_generator.sv */
// LED pattern generator: off, on, blink, counted blink and triangle breath.
//
// Channels: each poll on in_valid/in_ready carries a millisecond timestamp
// in_now_ms. A result on out_valid/out_ready carries the brightness and
// two flags; it is given on the first poll, on a level change, when new
// settings are rejected, or when a counted blink runs out.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (0 mode, 1 period, 2 duty, 3 repeats); any write marks settings pending,
// and the next poll checks and applies them. Write only while idle.
// Timing: one poll at a time: check, phase, level; blink adds a phase
// division (and an on-time step when blink settings are applied), breath
// a ramp division too. One divider, DW = max(TIME_BITS, 24) bits, one bit
// per cycle, is shared by both; the on time uses a registered product.
// At reset the pattern is off with no settings pending, and no result waits.
// When the receiver stalls, the result is held; the next poll is still
// accepted, and it waits at the end only if it has a result of its own.
// Depends on ledpg_pkg, ledpg_ctrl, ledpg_datapath and ledpg_div.
`timescale 1ns / 1ps

module led_pattern_generator
  import ledpg_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TIME_BITS-1:0]   in_now_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEVEL_W-1:0]     out_brightness,
  output logic                   out_settings_rejected,
  output logic                   out_count_finished
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ledpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ledpg_datapath #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_now_ms             (in_now_ms),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_brightness        (out_brightness),
    .out_settings_rejected (out_settings_rejected),
    .out_count_finished    (out_count_finished)
  );

`ifndef ASSERT_OFF
  a_one_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.main_div_start, cmd.breath_div_start}))
    else $error("more than one divider start at once");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.main_div_start || cmd.breath_div_start) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("poll accepted while previous poll still in work");

  a_finish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && sts.emit) |=> out_valid)
    else $error("result lost at hand-off");
`endif

endmodule
